>>> rtl/vfp_pkg.sv
// Shared types and constants for the vision frame parser.
package vfp_pkg;

    // Frame layout
    localparam logic [7:0] HDR_FIRST  = 8'hA3;
    localparam logic [7:0] HDR_SECOND = 8'hB3;
    localparam logic [7:0] TRAILER    = 8'hC3;
    localparam int unsigned FRAME_LEN = 7;
    localparam int unsigned BODY_LEN  = 4;

    localparam int unsigned POS_W  = 3;
    localparam int unsigned BODY_W = 2;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [BODY_W-1:0] body_idx_t;

    // Frame positions
    localparam pos_t POS_HDR0    = 3'd0;
    localparam pos_t POS_HDR1    = 3'd1;
    localparam pos_t POS_BODY0   = 3'd2;
    localparam pos_t POS_TRAILER = pos_t'(FRAME_LEN - 1);
    localparam pos_t POS_BAD     = pos_t'(FRAME_LEN);

    // Request codes; the fourth code is a no-op
    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_TAKE  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_code_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_data;
    } vfp_req_t;

    typedef struct packed {
        logic        frame_done;
        logic        target_found;
        logic [7:0]  target_id;
        logic [15:0] target_x;
        logic [7:0]  target_y;
        logic        frame_pending;
        logic        frame_taken;
    } vfp_res_t;

endpackage

>>> rtl/vfp_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
interface vfp_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/vfp_core.sv
// Frame scanner state and combinational update for one request.
module vfp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  vfp_pkg::vfp_req_t req,
    output vfp_pkg::vfp_res_t res
);
    import vfp_pkg::*;

    pos_t        pos_reg, pos_next;
    logic        found_reg, found_next;
    logic        pending_reg, pending_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] x_reg, x_next;
    logic [7:0]  y_reg, y_next;
    logic [7:0]  body_reg [BODY_LEN];

    pos_t        pos_eff;
    body_idx_t   body_idx;
    logic        body_we;
    logic        done;
    logic        taken;

    assign pos_eff  = (pos_reg == POS_BAD) ? POS_HDR0 : pos_reg;
    assign body_idx = pos_eff[BODY_W-1:0] - body_idx_t'(POS_BODY0);

    // Next state for the request in the input register
    always_comb
    begin
        pos_next     = pos_reg;
        found_next   = found_reg;
        pending_next = pending_reg;
        id_next      = id_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        body_we      = 1'b0;
        done         = 1'b0;
        taken        = 1'b0;
        unique case (req.req_type)
            REQ_BYTE:
            begin
                priority if (pos_eff == POS_HDR0)
                begin
                    found_next = 1'b0;
                    pos_next   = (req.rx_data == HDR_FIRST) ? POS_HDR1 : POS_HDR0;
                end
                else if (pos_eff == POS_HDR1)
                begin
                    pos_next = (req.rx_data == HDR_SECOND) ? POS_BODY0 : POS_HDR0;
                end
                else if (pos_eff != POS_TRAILER)
                begin
                    body_we  = 1'b1;
                    pos_next = pos_eff + pos_t'(1);
                end
                else
                begin
                    if (req.rx_data == TRAILER)
                    begin
                        id_next      = body_reg[0];
                        x_next       = {body_reg[1], body_reg[2]};
                        y_next       = body_reg[3];
                        found_next   = 1'b1;
                        pending_next = 1'b1;
                        done         = 1'b1;
                    end
                    pos_next = POS_HDR0;
                end
            end
            REQ_TAKE:
            begin
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    taken        = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                found_next   = 1'b0;
                pending_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Result reflects the state after this request
    always_comb
    begin
        res.frame_done    = done;
        res.target_found  = found_next;
        res.target_id     = id_next;
        res.target_x      = x_next;
        res.target_y      = y_next;
        res.frame_pending = pending_next;
        res.frame_taken   = taken;
    end

    // Control and latched frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_HDR0;
            found_reg   <= 1'b0;
            pending_reg <= 1'b0;
            id_reg      <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            found_reg   <= found_next;
            pending_reg <= pending_next;
            id_reg      <= id_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
        end
    end

    // Body bytes of the frame being assembled
    always_ff @(posedge clk)
    begin
        if (step && body_we)
        begin
            body_reg[body_idx] <= req.rx_data;
        end
    end

    a_done_sets_flags: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.frame_done |-> res.target_found && res.frame_pending)
        else $error("frame completed without found/pending");

    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.frame_done |=> pos_reg == POS_HDR0)
        else $error("scanner did not restart after a good frame");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != POS_BAD)
        else $error("frame position out of range");

    a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.frame_taken |=> !pending_reg)
        else $error("pending still set after a take");

endmodule

>>> rtl/vision_frame_parser.sv
// Top level: request register, frame scanner and result register.
//
//   channel   dir   payload                                    transaction
//   request   in    req_type, rx_data                          valid & ready
//   result    out   frame_done, target_found, target_id,       valid & ready
//                   target_x, target_y, frame_pending,
//                   frame_taken
//
// One request per cycle sustained while result.ready holds; a taken request passes
// the request register, then the result register, before its result is valid.
// rst_n clears the scanner position, flags, latched frame and valid bits.
// A stalled result holds the pipe; request.ready follows result.ready
// through the advance term, so nothing is lost or repeated.
module vision_frame_parser (
    input  logic         clk,
    input  logic         rst_n,
    vfp_stream_if.sink   request,
    vfp_stream_if.source result
);
    import vfp_pkg::*;

    logic     in_vld_reg, in_vld_next;
    vfp_req_t req_reg, req_next;
    logic     out_vld_reg, out_vld_next;
    vfp_res_t res_reg, res_next;

    logic     advance;
    logic     step;
    logic     req_fire;
    vfp_res_t core_res;

    // Handshake control
    assign advance       = !out_vld_reg || result.ready;
    assign step          = in_vld_reg && advance;
    assign request.ready = !in_vld_reg || advance;
    assign req_fire      = request.valid && request.ready;

    assign result.valid = out_vld_reg;
    assign result.data  = res_reg;

    vfp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (req_reg),
        .res   (core_res)
    );

    // Next values of the stage registers
    always_comb
    begin
        in_vld_next  = in_vld_reg;
        req_next     = req_reg;
        out_vld_next = out_vld_reg;
        res_next     = res_reg;
        if (req_fire)
        begin
            in_vld_next = 1'b1;
            req_next    = request.data;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end
        if (step)
        begin
            out_vld_next = 1'b1;
            res_next     = core_res;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

endmodule

>>> tb/vision_frame_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the vision frame parser: frames, requests and back-pressure.
module vision_frame_parser_tb;
    import vfp_pkg::*;

    localparam logic [1:0]  REQ_NOP     = 2'd3;   // unused request code, must change nothing
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned TAIL_CYCLES = 8;      // covers the two-stage result latency

    typedef enum logic {SINK_OPEN, SINK_CHOPPY} sink_mode_t;

    logic clk;
    logic rst_n;

    vfp_stream_if #(.payload_t(vfp_req_t)) req_if ();
    vfp_stream_if #(.payload_t(vfp_res_t)) res_if ();

    vision_frame_parser u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if)
    );

    // Tracked parser state
    pos_t        scan_pos;
    logic [7:0]  scan_body [BODY_LEN];
    logic        lat_found;
    logic [7:0]  lat_id;
    logic [15:0] lat_x;
    logic [7:0]  lat_y;
    logic        lat_pending;

    vfp_res_t    target_reports [$];

    int unsigned mismatch_total;
    int unsigned clock_count;
    int unsigned items_sent;

    // Sender pacing
    bit          send_idle_en;
    bit          req_offered;
    int unsigned burst_left;

    // Receiver pacing
    sink_mode_t  sink_mode;
    int unsigned hold_request;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run-time guard
    always @(posedge clk)
    begin
        clock_count++;
        if (clock_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Next result of the parser for one accepted request; updates tracked state
    function automatic vfp_res_t next_target_report(input vfp_req_t item);
        vfp_res_t rep;
        pos_t     p;
        rep = '0;
        case (item.req_type)
            REQ_BYTE:
            begin
                p = scan_pos;
                if (p >= pos_t'(FRAME_LEN))
                    p = POS_HDR0;
                if (p == POS_HDR0)
                begin
                    lat_found = 1'b0;
                    scan_pos  = (item.rx_data == HDR_FIRST) ? POS_HDR1 : POS_HDR0;
                end
                else if (p == POS_HDR1)
                begin
                    scan_pos = (item.rx_data == HDR_SECOND) ? POS_BODY0 : POS_HDR0;
                end
                else if (p < POS_TRAILER)
                begin
                    scan_body[body_idx_t'(p - POS_BODY0)] = item.rx_data;
                    scan_pos = p + 1'b1;
                end
                else
                begin
                    if (item.rx_data == TRAILER)
                    begin
                        lat_id      = scan_body[0];
                        lat_x       = {scan_body[1], scan_body[2]};
                        lat_y       = scan_body[3];
                        lat_found   = 1'b1;
                        lat_pending = 1'b1;
                        rep.frame_done = 1'b1;
                    end
                    scan_pos = POS_HDR0;
                end
            end
            REQ_TAKE:
            begin
                if (lat_pending)
                begin
                    lat_pending     = 1'b0;
                    rep.frame_taken = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                lat_found   = 1'b0;
                lat_pending = 1'b0;
            end
            default: ;
        endcase
        rep.target_found  = lat_found;
        rep.target_id     = lat_id;
        rep.target_x      = lat_x;
        rep.target_y      = lat_y;
        rep.frame_pending = lat_pending;
        return rep;
    endfunction

    // Result checker: each transaction against the oldest expectation
    always @(posedge clk)
    begin
        vfp_res_t want;
        vfp_res_t got;
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            got = res_if.data;
            if (target_reports.size() == 0)
            begin
                if (mismatch_total < 10)
                    $display("unexpected result: x=%04h id=%02h", got.target_x, got.target_id);
                mismatch_total++;
            end
            else
            begin
                want = target_reports.pop_front();
                if (got.frame_done    !== want.frame_done    ||
                    got.target_found  !== want.target_found  ||
                    got.target_id     !== want.target_id     ||
                    got.target_x      !== want.target_x      ||
                    got.target_y      !== want.target_y      ||
                    got.frame_pending !== want.frame_pending ||
                    got.frame_taken   !== want.frame_taken)
                begin
                    if (mismatch_total < 10)
                    begin
                        $display("mismatch: want done=%0b found=%0b id=%02h x=%04h y=%02h pend=%0b taken=%0b",
                                 want.frame_done, want.target_found, want.target_id,
                                 want.target_x, want.target_y, want.frame_pending,
                                 want.frame_taken);
                        $display("          got  done=%0b found=%0b id=%02h x=%04h y=%02h pend=%0b taken=%0b",
                                 got.frame_done, got.target_found, got.target_id,
                                 got.target_x, got.target_y, got.frame_pending,
                                 got.frame_taken);
                    end
                    mismatch_total++;
                end
            end
        end
    end

    // Receiver: open, run-length stall pattern, or a long hold-off on request
    initial
    begin
        int unsigned run_left;
        int unsigned hold_left;
        logic        rdy_now;
        run_left  = 0;
        hold_left = 0;
        rdy_now   = 1'b0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rdy_now = 1'b0;
            end
            else if (sink_mode == SINK_OPEN)
            begin
                rdy_now = 1'b1;
            end
            else if (run_left == 0)
            begin
                rdy_now = !rdy_now;
                if (rdy_now)
                    run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 8);
                else
                    run_left = $urandom_range(1, 5);
            end
            else
            begin
                run_left--;
            end
            res_if.ready <= rdy_now;
        end
    end

    // Offer one transaction, wait for acceptance, then maybe idle between bursts
    task automatic send_request(input logic [1:0] code, input logic [7:0] rx_byte);
        vfp_req_t    item;
        int unsigned gap;
        item.req_type = code;
        item.rx_data  = rx_byte;
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        req_offered  = 1'b1;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
        target_reports.push_back(next_target_report(item));
        if (send_idle_en)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                         : $urandom_range(1, 8);
                req_if.valid <= 1'b0;
                req_offered  = 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic stop_offering();
        if (req_offered)
        begin
            req_if.valid <= 1'b0;
            req_offered  = 1'b0;
        end
    endtask

    task automatic wait_drained();
        stop_offering();
        while (target_reports.size() != 0)
            @(posedge clk);
    endtask

    // Take, clear or unused request with random data
    task automatic send_side_request();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            send_request(REQ_TAKE, 8'($urandom));
        else if (pick < 8)
            send_request(REQ_CLEAR, 8'($urandom));
        else
            send_request(REQ_NOP, 8'($urandom));
    endtask

    // Whole frame; side requests may be slipped in between its bytes
    task automatic send_frame(input logic [7:0] id, input logic [15:0] x,
                              input logic [7:0] y, input logic [7:0] tail,
                              input int unsigned side_pct);
        logic [7:0] frame_bytes [FRAME_LEN];
        frame_bytes[0] = HDR_FIRST;
        frame_bytes[1] = HDR_SECOND;
        frame_bytes[2] = id;
        frame_bytes[3] = x[15:8];
        frame_bytes[4] = x[7:0];
        frame_bytes[5] = y;
        frame_bytes[6] = tail;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (i != 0 && $urandom_range(0, 99) < side_pct)
                send_side_request();
            send_request(REQ_BYTE, frame_bytes[i]);
        end
    endtask

    // Mostly good frames with random content, plus broken frames, side requests and noise
    task automatic random_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        logic [7:0]  b;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                send_frame(8'($urandom), 16'($urandom), 8'($urandom), TRAILER, 10);
            end
            else if (pick < 65)
            begin
                // bad trailer
                b = 8'($urandom);
                if (b == TRAILER)
                    b = b ^ 8'h01;
                send_frame(8'($urandom), 16'($urandom), 8'($urandom), b, 10);
            end
            else if (pick < 73)
            begin
                // bad second header byte, sometimes another first header byte
                send_request(REQ_BYTE, HDR_FIRST);
                b = $urandom_range(0, 1) ? HDR_FIRST : 8'($urandom);
                if (b == HDR_SECOND)
                    b = 8'h00;
                send_request(REQ_BYTE, b);
            end
            else if (pick < 90)
            begin
                send_side_request();
            end
            else
            begin
                send_request(REQ_BYTE, 8'($urandom));
            end
        end
    endtask

    task automatic test_directed();
        send_idle_en = 1'b1;
        sink_mode    = SINK_CHOPPY;
        // requests with nothing latched
        send_request(REQ_TAKE, 8'hFF);
        send_request(REQ_CLEAR, 8'h00);
        send_request(REQ_NOP, 8'h5A);
        // all-zero frame, then take it twice
        send_frame(8'h00, 16'h0000, 8'h00, TRAILER, 0);
        send_request(REQ_TAKE, 8'h00);
        send_request(REQ_TAKE, 8'hFF);
        // all-ones frame with a clear and an unused request in the middle
        send_request(REQ_BYTE, HDR_FIRST);
        send_request(REQ_BYTE, HDR_SECOND);
        send_request(REQ_BYTE, 8'hFF);
        send_request(REQ_CLEAR, 8'hFF);
        send_request(REQ_BYTE, 8'hFF);
        send_request(REQ_BYTE, 8'hFF);
        send_request(REQ_NOP, 8'h00);
        send_request(REQ_BYTE, 8'hFF);
        send_request(REQ_BYTE, TRAILER);
        // any byte at frame start drops found
        send_request(REQ_BYTE, 8'h00);
        // repeated first header byte is not taken as a new start
        send_request(REQ_BYTE, HDR_FIRST);
        send_request(REQ_BYTE, HDR_FIRST);
        send_request(REQ_BYTE, HDR_SECOND);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        send_idle_en = 1'b1;
        sink_mode    = SINK_CHOPPY;
        random_traffic(560);
        wait_drained();
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_back_pressure();
        send_idle_en = 1'b0;
        sink_mode    = SINK_OPEN;
        hold_request = 60;
        for (int i = 0; i < 6; i++)
            send_frame(8'($urandom), 16'($urandom), 8'($urandom), TRAILER, 0);
        wait_drained();
    endtask

    task automatic test_full_rate();
        send_idle_en = 1'b0;
        sink_mode    = SINK_OPEN;
        random_traffic(80);
        wait_drained();
    endtask

    initial
    begin
        mismatch_total = 0;
        clock_count    = 0;
        items_sent     = 0;
        burst_left     = 0;
        req_offered    = 1'b0;
        send_idle_en   = 1'b0;
        sink_mode      = SINK_OPEN;
        hold_request   = 0;
        scan_pos       = POS_HDR0;
        lat_found      = 1'b0;
        lat_id         = '0;
        lat_x          = '0;
        lat_y          = '0;
        lat_pending    = 1'b0;
        for (int i = 0; i < BODY_LEN; i++)
            scan_body[i] = '0;
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();
        test_back_pressure();
        test_full_rate();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (target_reports.size() != 0)
            mismatch_total++;
        if (mismatch_total == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/vfp_pkg.sv
rtl/vfp_stream_if.sv
rtl/vfp_core.sv
rtl/vision_frame_parser.sv
tb/vision_frame_parser_tb.sv
